>>> rtl/rqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared types and constants for the record quicksort block.
// ----------------------------------------------------------------------------
package rqs_pkg;

  localparam int FIELD_W = 16;
  localparam int TAG_W   = 4;

  // sort_key codes
  localparam logic KEY_BARCODE = 1'b0;
  localparam logic KEY_PRICE   = 1'b1;

  // register index as decoded from paddr[2]
  localparam logic REG_SORT_KEY = 1'b0;

  typedef struct packed {
    logic [FIELD_W-1:0] item_barcode;
    logic [FIELD_W-1:0] item_price;
    logic [TAG_W-1:0]   item_tag;
    logic               last_record;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_barcode;
    logic [FIELD_W-1:0] out_price;
    logic [TAG_W-1:0]   out_tag;
    logic               out_last;
  } result_t;

  typedef struct packed {
    logic [FIELD_W-1:0] barcode;
    logic [FIELD_W-1:0] price;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

>>> rtl/rqs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module rqs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 36
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/rqs_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_cmp
// Key compare unit: holds the pivot key and compares a record against it.
// ----------------------------------------------------------------------------
module rqs_cmp #(
  parameter int KEY_WIDTH = 16
) (
  input  logic          clk,
  input  rqs_pkg::rec_t rec,
  input  logic          sort_key,
  input  logic          load_piv,
  output logic          lt,
  output logic          gt
);
  import rqs_pkg::*;

  // keys are compared on their low KEY_WIDTH bits, capped at the 16-bit field width
  localparam int KW = (KEY_WIDTH < FIELD_W) ? KEY_WIDTH : FIELD_W;

  logic [FIELD_W-1:0] field;
  logic [KW-1:0]      key;
  logic [KW-1:0]      piv;

  always_comb begin
    field = (sort_key == KEY_PRICE) ? rec.price : rec.barcode;
    key   = field[KW-1:0];
    lt    = key < piv;
    gt    = key > piv;
  end

  always_ff @(posedge clk) begin
    if (load_piv) begin
      piv <= key;
    end
  end

endmodule

>>> rtl/record_quicksort_by_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_quicksort_by_key
// Loads a set of records, sorts them by barcode or price, emits them.
// ----------------------------------------------------------------------------
// Use:
//   Records enter on item, one per cycle, taken when start is high and busy
//   low. A record that carries last_record closes the set; records beyond
//   MAX_RECORDS are dropped. busy then rises and stays high through the sort
//   and the output run. Sorted records leave on result, one per cycle, each
//   marked by done for that single cycle; out_last flags the final one.
//   The user writes sort_key over the APB port only while the block is idle;
//   the block itself does not enforce this.
// Sort:
//   Hoare partitioning on a one-read, one-write record memory and one key
//   comparator: each scan step reads a record and compares it, except at
//   the range bound; each pass runs loop checks, each swap reads both records
//   and writes them back crossed, each range takes a pop, fetch, pivot read
//   and load, and the two pushes. A final pop finds the stack empty (a set
//   of one skips the sort), the records stream out and busy drops.
// Reset:
//   rst clears the record count, range stack pointer, sort_key and the
//   sequencer. There is no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module record_quicksort_by_key #(
  parameter int MAX_RECORDS = 16,
  parameter int KEY_WIDTH   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rqs_pkg::item_t   item,
  output logic             done,
  output rqs_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rqs_pkg::*;

  localparam int IW  = $clog2(MAX_RECORDS);
  localparam int CW  = $clog2(MAX_RECORDS + 1);
  localparam int XW  = IW + 2;
  localparam int SD  = MAX_RECORDS + 2;
  localparam int SAW = $clog2(SD);
  localparam int SPW = $clog2(SD + 1);

  typedef enum logic [17:0] {
    ST_IDLE     = 18'h00001,
    ST_POP      = 18'h00002,
    ST_RANGE    = 18'h00004,
    ST_PIVOT    = 18'h00008,
    ST_PIV_LD   = 18'h00010,
    ST_OUTER    = 18'h00020,
    ST_S0_RD    = 18'h00040,
    ST_S0_CMP   = 18'h00080,
    ST_S1_RD    = 18'h00100,
    ST_S1_CMP   = 18'h00200,
    ST_SWAP_CHK = 18'h00400,
    ST_SW_A     = 18'h00800,
    ST_SW_B     = 18'h01000,
    ST_SW_C     = 18'h02000,
    ST_PUSH_R   = 18'h04000,
    ST_PUSH_L   = 18'h08000,
    ST_EMIT     = 18'h10000,
    ST_DONE     = 18'h20000
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [SPW-1:0]      sp;
  logic [CW-1:0]       emit_idx;
  logic                emit_pend;
  logic                emit_last;
  logic                sort_key;
  logic [IW-1:0]       lo;
  logic [IW-1:0]       hi;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] x1;
  logic signed [XW-1:0] lo_x;
  logic signed [XW-1:0] hi_x;
  logic [IW-1:0]       mid;
  rec_t                rec_a;

  logic                accept;
  logic                room;
  logic                stk_room;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  rec_t                mem_wdata;
  logic [IW-1:0]       mem_raddr;
  rec_t                mem_rdata;

  logic                stk_we;
  logic [SAW-1:0]      stk_waddr;
  logic [2*IW-1:0]     stk_wdata;
  logic [SAW-1:0]      stk_raddr;
  logic [2*IW-1:0]     stk_rdata;

  logic                cmp_lt;
  logic                cmp_gt;
  logic                cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SORT_KEY) ? {31'b0, sort_key} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key <= KEY_BARCODE;
    end else if (cfg_wr && paddr[2] == REG_SORT_KEY) begin
      sort_key <= pwdata[0];
    end
  end

  // ---------------- datapath helpers ----------------
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign room     = count < CW'(MAX_RECORDS);
  assign stk_room = sp < SPW'(SD);
  assign lo_x     = $signed({2'b00, lo});
  assign hi_x     = $signed({2'b00, hi});
  assign mid      = lo + ((hi - lo) >> 1);
  assign count_next = room ? count + CW'(1) : count;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = x0[IW-1:0];
    mem_wdata = mem_rdata;
    case (state)
      ST_IDLE: begin
        mem_we    = accept && room;
        mem_waddr = count[IW-1:0];
        mem_wdata = '{barcode: item.item_barcode, price: item.item_price,
                      tag: item.item_tag};
      end
      ST_SW_B: begin
        mem_we    = 1'b1;
        mem_waddr = x0[IW-1:0];
        mem_wdata = mem_rdata;
      end
      ST_SW_C: begin
        mem_we    = 1'b1;
        mem_waddr = x1[IW-1:0];
        mem_wdata = rec_a;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state)
      ST_PIVOT: mem_raddr = mid;
      ST_S1_RD: mem_raddr = x1[IW-1:0];
      ST_SW_A:  mem_raddr = x1[IW-1:0];
      ST_EMIT:  mem_raddr = emit_idx[IW-1:0];
      default:  mem_raddr = x0[IW-1:0];
    endcase
  end

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sp[SAW-1:0];
    stk_wdata = {lo, x1[IW-1:0]};
    stk_raddr = SAW'(sp - SPW'(1));
    case (state)
      ST_IDLE: begin
        stk_we    = accept && item.last_record && (count_next >= CW'(2));
        stk_waddr = '0;
        stk_wdata = {IW'(0), IW'(count_next - CW'(1))};
      end
      ST_PUSH_R: begin
        stk_we    = (x0 < hi_x) && stk_room;
        stk_wdata = {x0[IW-1:0], hi};
      end
      ST_PUSH_L: begin
        stk_we    = (lo_x < x1) && stk_room;
        stk_wdata = {lo, x1[IW-1:0]};
      end
      default: begin
        stk_we = 1'b0;
      end
    endcase
  end

  rqs_ram #(.DEPTH(MAX_RECORDS), .WIDTH(REC_W)) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  rqs_ram #(.DEPTH(SD), .WIDTH(2 * IW)) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  rqs_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp (
    .clk      (clk),
    .rec      (mem_rdata),
    .sort_key (sort_key),
    .load_piv (state == ST_PIV_LD),
    .lt       (cmp_lt),
    .gt       (cmp_gt)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      sp        <= '0;
      emit_pend <= 1'b0;
    end else begin
      emit_pend <= (state == ST_EMIT);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (item.last_record) begin
              emit_idx <= '0;
              if (count_next >= CW'(2)) begin
                sp    <= SPW'(1);
                state <= ST_POP;
              end else begin
                state <= ST_EMIT;
              end
            end
          end
        end
        ST_POP: begin
          if (sp == '0) begin
            emit_idx <= '0;
            state    <= ST_EMIT;
          end else begin
            sp    <= sp - SPW'(1);
            state <= ST_RANGE;
          end
        end
        ST_RANGE: begin
          lo    <= stk_rdata[2*IW-1:IW];
          hi    <= stk_rdata[IW-1:0];
          x0    <= $signed({2'b00, stk_rdata[2*IW-1:IW]});
          x1    <= $signed({2'b00, stk_rdata[IW-1:0]});
          state <= ST_PIVOT;
        end
        ST_PIVOT:  state <= ST_PIV_LD;
        ST_PIV_LD: state <= ST_OUTER;
        ST_OUTER:  state <= (x0 <= x1) ? ST_S0_RD : ST_PUSH_R;
        ST_S0_RD:  state <= (x0 < hi_x) ? ST_S0_CMP : ST_S1_RD;
        ST_S0_CMP: begin
          if (cmp_lt) begin
            x0    <= x0 + XW'(1);
            state <= ST_S0_RD;
          end else begin
            state <= ST_S1_RD;
          end
        end
        ST_S1_RD:  state <= (x1 > lo_x) ? ST_S1_CMP : ST_SWAP_CHK;
        ST_S1_CMP: begin
          if (cmp_gt) begin
            x1    <= x1 - XW'(1);
            state <= ST_S1_RD;
          end else begin
            state <= ST_SWAP_CHK;
          end
        end
        ST_SWAP_CHK: state <= (x0 <= x1) ? ST_SW_A : ST_PUSH_R;
        ST_SW_A: begin
          rec_a <= mem_rdata;
          state <= ST_SW_B;
        end
        ST_SW_B: state <= ST_SW_C;
        ST_SW_C: begin
          x0    <= x0 + XW'(1);
          x1    <= x1 - XW'(1);
          state <= ST_OUTER;
        end
        ST_PUSH_R: begin
          if (stk_we) begin
            sp <= sp + SPW'(1);
          end
          state <= ST_PUSH_L;
        end
        ST_PUSH_L: begin
          if (stk_we) begin
            sp <= sp + SPW'(1);
          end
          state <= ST_POP;
        end
        ST_EMIT: begin
          emit_last <= (emit_idx == count - CW'(1));
          emit_idx  <= emit_idx + CW'(1);
          if (emit_idx == count - CW'(1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          count <= '0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result record fields come straight from the registered memory read; out_last from emit_last
  assign done               = emit_pend;
  assign result.out_barcode = mem_rdata.barcode;
  assign result.out_price   = mem_rdata.price;
  assign result.out_tag     = mem_rdata.tag;
  assign result.out_last    = emit_last;

  // ---------------- assertions ----------------
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a run");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (done && result.out_last) |=> !done)
    else $error("result after the last of the run");

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(SD))
    else $error("range stack pointer overrun");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RECORDS))
    else $error("record count overrun");

  a_scan_low: assert property (@(posedge clk) disable iff (rst)
    (state == ST_S0_RD) |-> (x0 >= lo_x))
    else $error("left scan below range");

endmodule

>>> dv/record_quicksort_by_key_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_quicksort_by_key_tb
// Self-checking bench for the record quicksort block. Record sets are loaded
// under both sort keys, with single, full and overflowing sets and heavy
// key duplication. A local Hoare-partition sorter gives the expected
// emission order, and each strobed result is checked field by field.
// ----------------------------------------------------------------------------
module record_quicksort_by_key_tb;
  import rqs_pkg::*;

  localparam int SET_DEPTH  = 16;
  localparam int KEY_BITS   = 16;
  localparam int STALL_LIMIT = 50000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        done;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  item_t   feed_q[$];
  result_t sorted_q[$];
  rec_t    shelf[SET_DEPTH];
  int      shelf_count = 0;
  logic    key_sel = KEY_BARCODE;
  int      idle_pct = 0;
  int      errors = 0;
  int      stall_cycles = 0;

  record_quicksort_by_key #(
    .MAX_RECORDS(SET_DEPTH),
    .KEY_WIDTH  (KEY_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [KEY_BITS-1:0] key_at(input int i);
    return (key_sel == KEY_PRICE) ? shelf[i].price[KEY_BITS-1:0]
                                  : shelf[i].barcode[KEY_BITS-1:0];
  endfunction

  // Hoare partition, middle pivot, explicit range stack
  function automatic void sort_shelf();
    int lo_st[SET_DEPTH+2];
    int hi_st[SET_DEPTH+2];
    int sp, lo, hi, x0, x1;
    logic [KEY_BITS-1:0] piv;
    rec_t t;
    sp = 0;
    if (shelf_count < 2) return;
    lo_st[0] = 0;
    hi_st[0] = shelf_count - 1;
    sp = 1;
    while (sp > 0) begin
      sp--;
      lo = lo_st[sp];
      hi = hi_st[sp];
      x0 = lo;
      x1 = hi;
      piv = key_at(lo + (hi - lo) / 2);
      while (x0 <= x1) begin
        while (x0 < hi && key_at(x0) < piv) x0++;
        while (x1 > lo && key_at(x1) > piv) x1--;
        if (x0 <= x1) begin
          t = shelf[x0];
          shelf[x0] = shelf[x1];
          shelf[x1] = t;
          x0++;
          x1--;
        end
      end
      if (x0 < hi && sp < SET_DEPTH + 2) begin
        lo_st[sp] = x0;
        hi_st[sp] = hi;
        sp++;
      end
      if (lo < x1 && sp < SET_DEPTH + 2) begin
        lo_st[sp] = lo;
        hi_st[sp] = x1;
        sp++;
      end
    end
  endfunction

  function automatic void load_record(input item_t it);
    if (shelf_count < SET_DEPTH) begin
      shelf[shelf_count] = '{barcode: it.item_barcode, price: it.item_price,
                             tag: it.item_tag};
      shelf_count++;
    end
    if (it.last_record) begin
      sort_shelf();
      for (int i = 0; i < shelf_count; i++)
        sorted_q.push_back('{out_barcode: shelf[i].barcode, out_price: shelf[i].price,
                             out_tag: shelf[i].tag, out_last: (i == shelf_count - 1)});
      shelf_count = 0;
    end
  endfunction

  // driver: a new item goes out once the previous one has been taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      item  <= '0;
    end else if (!start || !busy) begin
      if (feed_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        item  <= feed_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predicts on accepted items, checks strobed results
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (start && !busy) load_record(item);
      if (done) begin
        if (sorted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", result));
        end else begin
          want = sorted_q.pop_front();
          if (result.out_barcode !== want.out_barcode)
            report_mismatch($sformatf("out_barcode %h, want %h",
                                      result.out_barcode, want.out_barcode));
          if (result.out_price !== want.out_price)
            report_mismatch($sformatf("out_price %h, want %h",
                                      result.out_price, want.out_price));
          if (result.out_tag !== want.out_tag)
            report_mismatch($sformatf("out_tag %h, want %h", result.out_tag, want.out_tag));
          if (result.out_last !== want.out_last)
            report_mismatch($sformatf("out_last %b, want %b",
                                      result.out_last, want.out_last));
        end
      end
      if ((start && !busy) || done || (psel && penable))
        stall_cycles <= 0;
      else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL record_quicksort_by_key");
        $finish;
      end else
        stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic item_t mk_item(input logic [15:0] b, input logic [15:0] p,
                                    input logic [3:0] t, input logic l);
    return '{item_barcode: b, item_price: p, item_tag: t, last_record: l};
  endfunction

  function automatic logic [15:0] pick_key(input int mode, input int i, input int n);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 3));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'((n - i) * 1021);
    endcase
  endfunction

  // queues one set; occasionally too many records so the tail is dropped
  task automatic add_set(output int n);
    int mode;
    mode = $urandom_range(0, 3);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(SET_DEPTH + 1, SET_DEPTH + 4)
                                    : $urandom_range(1, SET_DEPTH);
    for (int i = 0; i < n; i++)
      feed_q.push_back(mk_item(pick_key(mode, i, n), pick_key(mode, n - i, n),
                               4'($urandom), i == n - 1));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (feed_q.size() != 0 || start || sorted_q.size() != 0 || busy)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_sort_key(input logic v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SORT_KEY, 2'b00};
    pwdata  <= {31'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    key_sel = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== v)
      report_mismatch($sformatf("sort_key reads %b, want %b", prdata[0], v));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic phase_key[4];
    int   phase_idle[4];
    int   n, fed;
    phase_key  = '{KEY_PRICE, KEY_BARCODE, KEY_PRICE, KEY_BARCODE};
    phase_idle = '{0, 64, 10, 0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed sets under the barcode key
    write_sort_key(KEY_BARCODE);
    @(negedge clk);
    feed_q.push_back(mk_item(16'hFFFF, 16'hFFFF, 4'hF, 1'b1));
    feed_q.push_back(mk_item(16'h8000, 16'h0000, 4'h0, 1'b0));
    feed_q.push_back(mk_item(16'h8000, 16'h0001, 4'h1, 1'b1));
    // full set with extremes and ties; the last two records overflow
    for (int i = 0; i < SET_DEPTH + 2; i++)
      feed_q.push_back(mk_item((i % 3 == 0) ? 16'hFFFF : (i % 3 == 1) ? 16'h0000 : 16'(i * 4111),
                               (i % 2 == 0) ? 16'h0000 : 16'hFFFF, 4'(i),
                               i == SET_DEPTH + 1));

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_sort_key(phase_key[p]);
      idle_pct = phase_idle[p];
      @(negedge clk);
      fed = 0;
      while (fed < 50) begin
        add_set(n);
        fed += n;
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("PASS record_quicksort_by_key");
    else
      $display("FAIL record_quicksort_by_key");
    $finish;
  end

endmodule

>>> sim.f
rtl/rqs_pkg.sv
rtl/rqs_ram.sv
rtl/rqs_cmp.sv
rtl/record_quicksort_by_key.sv
dv/record_quicksort_by_key_tb.sv
